// ----- hw/rtl/sida_pkg.sv -----
`timescale 1ns / 1ps
package sida_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CALC_W          = 64;
  localparam int MAX_POW         = 19;

  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_ZERO  = 6'd48;

  // 10^k, k = 0..19; all fit in 64 unsigned bits
  function automatic logic [CALC_W-1:0] pow10(input int k);
    logic [CALC_W-1:0] p;
    case (k)
      0:  p = 64'd1;
      1:  p = 64'd10;
      2:  p = 64'd100;
      3:  p = 64'd1000;
      4:  p = 64'd10000;
      5:  p = 64'd100000;
      6:  p = 64'd1000000;
      7:  p = 64'd10000000;
      8:  p = 64'd100000000;
      9:  p = 64'd1000000000;
      10: p = 64'd10000000000;
      11: p = 64'd100000000000;
      12: p = 64'd1000000000000;
      13: p = 64'd10000000000000;
      14: p = 64'd100000000000000;
      15: p = 64'd1000000000000000;
      16: p = 64'd10000000000000000;
      17: p = 64'd100000000000000000;
      18: p = 64'd1000000000000000000;
      19: p = 64'd10000000000000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

  // decimal digits needed for the largest magnitude, 2^(w-1)
  function automatic int num_digits(input int w);
    int n;
    logic [CALC_W-1:0] top;
    n   = 1;
    top = 64'd1 << (w - 1);
    for (int k = 1; k <= MAX_POW; k++) begin
      if (pow10(k) <= top) n = k + 1;
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/signed_int_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// Signed integer to decimal ASCII text. Each input item is a VALUE_WIDTH-bit two's
// complement value; the output is its text, one character per item: an optional
// minus sign, then the digits most significant first with no leading zeros (zero
// gives "0"), tlast on the final character. The output carries one character per
// cycle while out_tready is high; a text has 1 to 11 characters at the default
// width (sign plus ten digits), up to 20 at 64 bits. The back end extracts one
// digit per cycle when not stalled, comparing the remainder with the nine multiples
// of the current power of ten. The front end registers sign and magnitude, finds the
// leading digit position, and hands the item on through a two-entry queue, so new
// values are taken while earlier text is still going out. A value passes the front
// register, the queue and the back-end state before reaching the output register.
module signed_int_to_decimal_ascii import sida_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    in_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [5:0] ascii_char
  output logic                                out_tlast   // is_last
);

  localparam int NDIG = num_digits(VALUE_WIDTH);
  localparam int POSW = $clog2(NDIG);
  localparam int EW   = 1 + POSW + VALUE_WIDTH;

  logic          push, q_full, pop, q_valid;
  logic [EW-1:0] push_data, q_data;
  logic [5:0]    out_char;

  sida_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_value  (in_tdata[VALUE_WIDTH-1:0]),
    .push      (push),
    .q_full    (q_full),
    .push_data (push_data)
  );

  sida_queue #(.DW(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  sida_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, out_char};

endmodule

// ----- hw/rtl/sida_front.sv -----
`timescale 1ns / 1ps
module sida_front import sida_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int NDIG = num_digits(VALUE_WIDTH),
  localparam int POSW = $clog2(NDIG),
  localparam int EW   = 1 + POSW + VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   push,
  input  logic                   q_full,
  output logic [EW-1:0]          push_data
);

  logic                   s1_v_r;
  logic                   s1_neg_r;
  logic [VALUE_WIDTH-1:0] s1_mag_r;
  logic [POSW-1:0]        msd_pos;
  logic [CALC_W-1:0]      mag_ext;

  assign push     = s1_v_r && !q_full;
  assign in_ready = !s1_v_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  // magnitude in unsigned arithmetic; the most negative value maps to 2^(W-1)
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_neg_r <= in_value[VALUE_WIDTH-1];
      s1_mag_r <= in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
    end
  end

  // position of the most significant digit: count of powers 10^k, k >= 1, <= magnitude
  always_comb begin
    mag_ext = CALC_W'(s1_mag_r);
    msd_pos = '0;
    for (int k = 1; k < NDIG; k++) begin
      if (mag_ext >= pow10(k)) msd_pos = msd_pos + POSW'(1);
    end
  end

  assign push_data = {s1_neg_r, msd_pos, s1_mag_r};

endmodule

// ----- hw/rtl/sida_queue.sv -----
`timescale 1ns / 1ps
module sida_queue import sida_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output logic [DW-1:0] q_data
);

  logic [DW-1:0] slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full    = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- hw/rtl/sida_back.sv -----
`timescale 1ns / 1ps
module sida_back import sida_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int NDIG = num_digits(VALUE_WIDTH),
  localparam int POSW = $clog2(NDIG),
  localparam int EW   = 1 + POSW + VALUE_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  logic [EW-1:0] q_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [5:0]    out_char,
  output logic          out_last
);

  logic                   busy_r, busy_nxt;
  logic                   neg_r, neg_nxt;
  logic [POSW-1:0]        pos_r, pos_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic                   out_v_r, out_v_nxt;
  logic [5:0]             char_r, char_nxt;
  logic                   last_r, last_nxt;

  logic                   adv;
  logic                   fin;
  logic [3:0]             digit;
  logic [CALC_W-1:0]      sub;
  logic [CALC_W-1:0]      rem_ext;
  logic [CALC_W-1:0]      p;
  logic [CALC_W-1:0]      thr;

  assign out_valid = out_v_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

  assign adv = !out_v_r || out_ready;
  assign fin = busy_r && !neg_r && (pos_r == '0);
  assign pop = adv && (!busy_r || fin) && q_valid;

  // digit at pos_r: largest j with j*10^pos <= remainder
  always_comb begin
    rem_ext = CALC_W'(rem_r);
    p       = pow10(int'(pos_r));
    digit   = '0;
    sub     = '0;
    thr     = '0;
    for (int j = 1; j <= 9; j++) begin
      thr = CALC_W'(j) * p;
      if (rem_ext >= thr) begin
        digit = 4'(j);
        sub   = thr;
      end
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    neg_nxt   = neg_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    out_v_nxt = out_v_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (adv) begin
      out_v_nxt = busy_r;
      if (busy_r) begin
        if (neg_r) begin
          char_nxt = CHAR_MINUS;
          last_nxt = 1'b0;
          neg_nxt  = 1'b0;
        end else begin
          char_nxt = CHAR_ZERO + 6'(digit);
          last_nxt = (pos_r == '0);
          rem_nxt  = rem_r - VALUE_WIDTH'(sub);
          if (pos_r == '0) begin
            busy_nxt = 1'b0;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
      // next item loads in the same cycle the previous one's last character goes out
      if (pop) begin
        busy_nxt = 1'b1;
        {neg_nxt, pos_nxt, rem_nxt} = q_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    pos_r  <= pos_nxt;
    rem_r  <= rem_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule

// ----- hw/rtl/sida_checker.sv -----
`timescale 1ns / 1ps
module sida_checker import sida_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic acc;
  logic mid_r;
  logic prev_minus_r;

  assign acc = out_tvalid && out_tready;

  // mid_r: inside a text run; prev_minus_r: last accepted item was a minus sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r        <= 1'b0;
      prev_minus_r <= 1'b0;
    end else if (acc) begin
      mid_r        <= !out_tlast;
      prev_minus_r <= (out_tdata[5:0] == CHAR_MINUS);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:6] == 2'b00 &&
      (out_tdata[5:0] == CHAR_MINUS ||
       (out_tdata[5:0] >= CHAR_ZERO && out_tdata[5:0] <= CHAR_ZERO + 6'd9)))
    else $error("character outside minus and digits");

  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    acc && mid_r |-> out_tdata[5:0] != CHAR_MINUS)
    else $error("minus sign inside a run");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc && out_tdata[5:0] == CHAR_MINUS |-> !out_tlast)
    else $error("run ends on a minus sign");

  a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    acc && prev_minus_r |-> out_tdata[5:0] != CHAR_ZERO)
    else $error("leading zero after minus sign");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- tb/signed_int_to_decimal_ascii_test.sv -----
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_test;
  import sida_pkg::*;

  localparam int VALUE_W   = 32;
  localparam int LIMIT     = 400000;
  localparam int HOLD_OFF  = 400;
  localparam int TAIL_WAIT = 30;

  typedef struct packed {
    logic [5:0] ch;
    logic       last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata = '0;   // [31:0] value
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;       // [5:0] ascii_char
  logic               out_tlast;       // is_last

  text_char_t expected_text[$];
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       hold_rx = 1'b0;
  int         mismatches = 0;
  int         values_sent = 0;
  int         negatives_sent = 0;
  int         chars_checked = 0;
  int         input_stalls = 0;
  int         cycle_count = 0;

  signed_int_to_decimal_ascii i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles, %0d chars still expected",
               cycle_count, expected_text.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a forced hold-off while hold_rx is set
  always @(posedge clk) begin
    out_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // decimal text of one value: optional minus, digits msd first, last flag on final digit
  function automatic void predict_text(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digits[20];
    int                 n;
    text_char_t         c;
    mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
    n = 0;
    do begin
      digits[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0);
    if (value[VALUE_W-1]) begin
      c.ch   = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.ch   = CHAR_ZERO + 6'(digits[k]);
      c.last = (k == 0);
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_tvalid && out_tready) begin
      chars_checked++;
      if (expected_text.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected char 0x%02h last=%0b", out_tdata[5:0], out_tlast);
      end else begin
        want = expected_text.pop_front();
        if (out_tdata[5:0] !== want.ch || out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Char mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                     want.ch, want.last, out_tdata[5:0], out_tlast);
        end
      end
    end
  end

  // offer one value; in_tvalid stays high into the next call unless a gap is drawn
  task automatic send_value(input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) begin
      input_stalls++;
      @(posedge clk);
    end
    predict_text(value);
    values_sent++;
    if (value[VALUE_W-1]) negatives_sent++;
  endtask

  task automatic test_directed();
    logic [VALUE_W-1:0] vals[$];
    vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
             32'd999999999, -32'sd999999999, -32'sd1000000000, 32'h5555_5555,
             32'hAAAA_AAAA, 32'd123456789, -32'sd5, 32'd2000000000};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // mostly random magnitudes spread over all digit counts, either sign
  task automatic test_random(input int count);
    logic [VALUE_W-1:0] v;
    repeat (count) begin
      case ($urandom_range(19))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = 32'($urandom_range(9));
        default: v = $urandom >> $urandom_range(31);
      endcase
      if ($urandom_range(1)) v = -v;
      send_value(v);
    end
  endtask

  // long receiver hold-off while values keep coming, so the input side backs up
  task automatic test_backpressure();
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_rx <= 1'b0;
      end
      test_random(20);
    join
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 88;
    test_directed();
    test_random(110);

    send_idle_pct = 88;
    recv_idle_pct = 13;
    test_random(110);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(110);
    test_backpressure();

    in_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Converted %0d values (%0d negative), checked %0d chars",
             values_sent, negatives_sent, chars_checked);
    $display("Input back-pressure seen on %0d cycles, %0d mismatches",
             input_stalls, mismatches);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
